>>> rtl/core/pclc_pkg.sv
`timescale 1ns / 1ps
package pclc_pkg;

	// default geometry
	localparam int CHIP_COUNT_DEF    = 4;
	localparam int CHIP_CHANNELS_DEF = 8;
	localparam int MAX_BOARDS_DEF    = 4;

	// fixed arithmetic
	localparam int BITS_PER_BYTE  = 8;
	localparam int WORD_BYTES     = 4;
	localparam int MASK_CHANNELS  = 32;
	localparam int SAMPLE_MAX     = 16;
	localparam int COUNT_W        = 7;
	localparam int CH_W           = 7;
	// bit offset inside one chip: up to 16 channels of 16 bits
	localparam int BITOFF_W       = 9;
	// byte base inside one board: up to 8 chips of 32 bytes plus rounding
	localparam int CBASE_W        = 10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SUM
	} pclc_state_t;

	// per-channel context handed to the step unit
	typedef struct packed {
		logic                enabled;
		logic                chip_end;
		logic [4:0]          bits;
		logic [BITOFF_W-1:0] bitoff;
		logic [CBASE_W-1:0]  cbase;
		logic [CH_W-1:0]     ch;
		logic [CH_W-1:0]     board_base;
	} pclc_ctx_t;

	// step unit results
	typedef struct packed {
		logic [5:0]          start_byte;
		logic [1:0]          span_bytes;
		logic [2:0]          right_shift;
		logic [6:0]          absolute_channel;
		logic [6:0]          board_bytes;
		logic [BITOFF_W-1:0] bitoff_nxt;
		logic [CBASE_W-1:0]  cbase_nxt;
	} pclc_step_t;

endpackage

>>> rtl/core/pclc_if.sv
`timescale 1ns / 1ps
interface pclc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  board_index;
	logic [31:0] channel_mask;
	logic [4:0]  sample_bits;
	logic        first_board;

	modport source (output valid, board_index, channel_mask, sample_bits, first_board,
		input ready);
	modport sink (input valid, board_index, channel_mask, sample_bits, first_board,
		output ready);
endinterface

interface pclc_out_if;
	logic       valid;
	logic       ready;
	logic       summary_flag;
	logic [1:0] chip_sel;
	logic [4:0] board_channel;
	logic [6:0] absolute_channel;
	logic [6:0] enabled_index;
	logic [5:0] start_byte;
	logic [1:0] span_bytes;
	logic [2:0] right_shift;
	logic [6:0] board_bytes;

	modport source (output valid, summary_flag, chip_sel, board_channel,
		absolute_channel, enabled_index, start_byte, span_bytes, right_shift,
		board_bytes, input ready);
	modport sink (input valid, summary_flag, chip_sel, board_channel,
		absolute_channel, enabled_index, start_byte, span_bytes, right_shift,
		board_bytes, output ready);
endinterface

>>> rtl/core/pclc_step.sv
`timescale 1ns / 1ps
module pclc_step
	import pclc_pkg::*;
(
	input  pclc_ctx_t  ctx,
	output pclc_step_t res
);

	logic [2:0]          start_bit;
	logic [4:0]          end_bit;
	logic [BITOFF_W-1:0] bitoff_add;
	logic [BITOFF_W-1:0] chip_bytes;

	// placement of the current sample
	always_comb begin
		start_bit = ctx.bitoff[2:0];
		end_bit = {2'b00, start_bit} + ctx.bits;
		res.span_bytes = 2'((end_bit + 5'd7) >> 3);
		res.right_shift = 3'd0 - end_bit[2:0];
		res.start_byte = 6'(ctx.cbase + CBASE_W'(ctx.bitoff >> 3));
		res.absolute_channel = 7'(ctx.board_base + ctx.ch);
	end

	// bit and byte accumulation, chip rounded to whole bytes
	always_comb begin
		bitoff_add = ctx.bitoff + (ctx.enabled ? BITOFF_W'(ctx.bits) : '0);
		chip_bytes = (bitoff_add + BITOFF_W'(7)) >> 3;
		if (ctx.chip_end) begin
			res.bitoff_nxt = '0;
			res.cbase_nxt = ctx.cbase + CBASE_W'(chip_bytes);
		end else begin
			res.bitoff_nxt = bitoff_add;
			res.cbase_nxt = ctx.cbase;
		end
	end

	// board total rounded up to whole words
	always_comb begin
		res.board_bytes = 7'((ctx.cbase + CBASE_W'(WORD_BYTES - 1))
			& ~CBASE_W'(WORD_BYTES - 1));
	end

endmodule

>>> rtl/core/pclc_seq.sv
`timescale 1ns / 1ps
module pclc_seq
	import pclc_pkg::*;
#(
	parameter int CHIP_COUNT    = CHIP_COUNT_DEF,
	parameter int CHIP_CHANNELS = CHIP_CHANNELS_DEF,
	parameter int MAX_BOARDS    = MAX_BOARDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pclc_in_if.sink     items,
	pclc_out_if.source  results,
	output pclc_ctx_t   ctx,
	input  pclc_step_t  step
);

	localparam int CHIP_W       = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;
	localparam int K_W          = (CHIP_CHANNELS > 1) ? $clog2(CHIP_CHANNELS) : 1;
	localparam int CH_PER_BOARD = CHIP_COUNT * CHIP_CHANNELS;

	pclc_state_t state_q, state_nxt;

	logic [31:0]         mask_q;
	logic [4:0]          bits_q;
	logic [CH_W-1:0]     board_base_q;
	logic [COUNT_W-1:0]  count_q;
	logic [CHIP_W-1:0]   chip_q;
	logic [K_W-1:0]      k_q;
	logic [CH_W-1:0]     ch_q;
	logic [BITOFF_W-1:0] bitoff_q;
	logic [CBASE_W-1:0]  cbase_q;

	logic       out_valid_q;
	logic       out_free;
	logic       accept;
	logic       scan_en;
	logic       sum_en;
	logic       chip_end;
	logic       last_ch;
	logic       ch_enabled;
	logic [4:0] bits_c;
	logic [1:0] board_c;

	// output register frees up when empty or being taken
	assign out_free = !out_valid_q || results.ready;
	assign accept = items.valid && items.ready;

	// scan position
	assign chip_end = (k_q == K_W'(CHIP_CHANNELS - 1));
	assign last_ch = chip_end && (chip_q == CHIP_W'(CHIP_COUNT - 1));
	assign ch_enabled = (ch_q < CH_W'(MASK_CHANNELS)) && mask_q[ch_q[4:0]];

	// clamp of incoming resolution and board index
	always_comb begin
		bits_c = items.sample_bits;
		if (items.sample_bits == 5'd0) begin
			bits_c = 5'd1;
		end else if (items.sample_bits > 5'(SAMPLE_MAX)) begin
			bits_c = 5'(SAMPLE_MAX);
		end
		board_c = items.board_index;
		if ({3'b000, items.board_index} >= 5'(MAX_BOARDS)) begin
			board_c = 2'(MAX_BOARDS - 1);
		end
	end

	// context for the step unit
	always_comb begin
		ctx.enabled = ch_enabled;
		ctx.chip_end = chip_end;
		ctx.bits = bits_q;
		ctx.bitoff = bitoff_q;
		ctx.cbase = cbase_q;
		ctx.ch = ch_q;
		ctx.board_base = board_base_q;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (items.valid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (out_free && last_ch) state_nxt = ST_SUM;
			end
			ST_SUM: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		items.ready = 1'b0;
		scan_en = 1'b0;
		sum_en = 1'b0;
		case (state_q)
			ST_IDLE: items.ready = 1'b1;
			ST_SCAN: scan_en = out_free;
			ST_SUM:  sum_en = out_free;
			default: items.ready = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept && items.first_board) begin
				count_q <= '0;
			end else if (scan_en && ch_enabled && count_q != '1) begin
				count_q <= count_q + 1'b1;
			end
			if ((scan_en && ch_enabled) || sum_en) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item latch and scan counters
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= items.channel_mask;
			bits_q <= bits_c;
			board_base_q <= CH_W'(32'(board_c) * CH_PER_BOARD);
			chip_q <= '0;
			k_q <= '0;
			ch_q <= '0;
			bitoff_q <= '0;
			cbase_q <= '0;
		end else if (scan_en) begin
			k_q <= chip_end ? '0 : k_q + 1'b1;
			chip_q <= chip_end ? chip_q + 1'b1 : chip_q;
			ch_q <= ch_q + 1'b1;
			bitoff_q <= step.bitoff_nxt;
			cbase_q <= step.cbase_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (scan_en && ch_enabled) begin
			results.summary_flag <= 1'b0;
			results.chip_sel <= 2'(chip_q);
			results.board_channel <= ch_q[4:0];
			results.absolute_channel <= step.absolute_channel;
			results.enabled_index <= count_q;
			results.start_byte <= step.start_byte;
			results.span_bytes <= step.span_bytes;
			results.right_shift <= step.right_shift;
			results.board_bytes <= '0;
		end else if (sum_en) begin
			results.summary_flag <= 1'b1;
			results.chip_sel <= '0;
			results.board_channel <= '0;
			results.absolute_channel <= '0;
			results.enabled_index <= '0;
			results.start_byte <= '0;
			results.span_bytes <= '0;
			results.right_shift <= '0;
			results.board_bytes <= step.board_bytes;
		end
	end

	assign results.valid = out_valid_q;

endmodule

>>> rtl/core/packed_channel_layout_calc.sv
`timescale 1ns / 1ps
// operation: after an item is accepted in idle, every board channel (CHIP_COUNT * CHIP_CHANNELS,
//   32 by default) is scanned, then the board summary is registered
// the single step unit handles one channel per cycle while the output is free; a new item
//   is accepted only back in idle, after the last one's summary is registered
// reset: arst_n clears the sequencer, the running enabled index and the result valid
module packed_channel_layout_calc
	import pclc_pkg::*;
#(
	parameter int CHIP_COUNT    = CHIP_COUNT_DEF,
	parameter int CHIP_CHANNELS = CHIP_CHANNELS_DEF,
	parameter int MAX_BOARDS    = MAX_BOARDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pclc_in_if.sink     items,
	pclc_out_if.source  results
);

	pclc_ctx_t  ctx;
	pclc_step_t step;

	// sequencer with channel scan and result register
	pclc_seq #(
		.CHIP_COUNT    (CHIP_COUNT),
		.CHIP_CHANNELS (CHIP_CHANNELS),
		.MAX_BOARDS    (MAX_BOARDS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.ctx     (ctx),
		.step    (step)
	);

	// shared placement arithmetic
	pclc_step u_step (
		.ctx (ctx),
		.res (step)
	);

endmodule

>>> rtl/core/pclc_checker.sv
`timescale 1ns / 1ps
module pclc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       summary_flag,
	input logic [1:0] chip_sel,
	input logic [4:0] board_channel,
	input logic [1:0] span_bytes,
	input logic [6:0] board_bytes
);

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted item");

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// stalled summary flag holds
	a_flag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(summary_flag))
		else $error("summary flag changed while stalled");

	// summary record carries only the byte total
	a_summary_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && summary_flag |-> chip_sel == 2'd0 && board_channel == 5'd0
			&& span_bytes == 2'd0 && board_bytes[1:0] == 2'd0)
		else $error("bad summary record");

	// channel record spans at least one byte and has no total
	a_channel_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !summary_flag |-> span_bytes != 2'd0 && board_bytes == 7'd0)
		else $error("bad channel record");

endmodule

bind packed_channel_layout_calc pclc_checker u_pclc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (items.valid),
	.in_ready      (items.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.summary_flag  (results.summary_flag),
	.chip_sel      (results.chip_sel),
	.board_channel (results.board_channel),
	.span_bytes    (results.span_bytes),
	.board_bytes   (results.board_bytes)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import pclc_pkg::*;

	localparam int ITEMS_PER_PHASE = 80;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int SCAN_CYCLES     = CHIP_COUNT_DEF * CHIP_CHANNELS_DEF;
	localparam int INDEX_MAX       = (1 << COUNT_W) - 1;
	localparam int REPORT_MAX      = 100;

	// one board description as it enters the block
	typedef struct packed {
		logic [1:0]  board_index;
		logic [31:0] channel_mask;
		logic [4:0]  sample_bits;
		logic        first_board;
	} board_item_t;

	// one layout descriptor or board summary as it leaves the block
	typedef struct packed {
		logic       summary_flag;
		logic [1:0] chip_sel;
		logic [4:0] board_channel;
		logic [6:0] absolute_channel;
		logic [6:0] enabled_index;
		logic [5:0] start_byte;
		logic [1:0] span_bytes;
		logic [2:0] right_shift;
		logic [6:0] board_bytes;
	} layout_desc_t;

	// layout predictor plus the queue of descriptors still owed by the block
	class layout_board;
		layout_desc_t pending[$];
		logic [6:0]   enabled_count;
		int           errors;
		int           boards;
		int           channel_recs;
		int           summaries;
		int           saturated_recs;

		function new();
			enabled_count  = '0;
			errors         = 0;
			boards         = 0;
			channel_recs   = 0;
			summaries      = 0;
			saturated_recs = 0;
		endfunction

		function void note_board(board_item_t it);
			int unsigned  bits;
			int unsigned  board;
			int unsigned  bitoff;
			int unsigned  start_bit;
			int unsigned  last_bit;
			int unsigned  chip_base;
			int unsigned  total;
			int unsigned  ch;
			layout_desc_t d;

			// out-of-range resolution and board index are clamped
			bits = 32'(it.sample_bits);
			if (bits < 1)
				bits = 1;
			if (bits > SAMPLE_MAX)
				bits = SAMPLE_MAX;
			board = 32'(it.board_index);
			if (board >= MAX_BOARDS_DEF)
				board = MAX_BOARDS_DEF - 1;
			if (it.first_board)
				enabled_count = '0;
			boards++;
			chip_base = 0;
			total     = 0;

			// samples packed msb-first within each chip, chips byte aligned
			for (int chip = 0; chip < CHIP_COUNT_DEF; chip++) begin
				bitoff = 0;
				for (int k = 0; k < CHIP_CHANNELS_DEF; k++) begin
					ch = chip * CHIP_CHANNELS_DEF + k;
					if (ch >= MASK_CHANNELS)
						continue;
					if (!it.channel_mask[ch[4:0]])
						continue;
					start_bit          = bitoff % BITS_PER_BYTE;
					last_bit           = start_bit + bits;
					d                  = '0;
					d.chip_sel         = 2'(chip);
					d.board_channel    = 5'(ch);
					d.absolute_channel = 7'(board * SCAN_CYCLES + ch);
					d.enabled_index    = enabled_count;
					d.start_byte       = 6'(chip_base + bitoff / BITS_PER_BYTE);
					d.span_bytes       = 2'((last_bit + BITS_PER_BYTE - 1) / BITS_PER_BYTE);
					d.right_shift      = 3'((BITS_PER_BYTE - last_bit % BITS_PER_BYTE)
						% BITS_PER_BYTE);
					pending = {pending, d};
					if (enabled_count == INDEX_MAX)
						saturated_recs++;
					else
						enabled_count++;
					bitoff += bits;
				end
				chip_base += (bitoff + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
				total     += (bitoff + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
			end

			// board summary closes the item
			d              = '0;
			d.summary_flag = 1'b1;
			d.board_bytes  = 7'((total + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES);
			pending = {pending, d};
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t ns: %s mismatch: expected %0d, actual %0d",
						$time, name, want, got);
				if (errors == REPORT_MAX)
					$display("further mismatch reports suppressed");
			end
		endfunction

		function void check_record(layout_desc_t got);
			layout_desc_t want;

			if (pending.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected descriptor: expected none, actual %h",
					$time, got);
				return;
			end
			want = pending.pop_front();
			if (want.summary_flag)
				summaries++;
			else
				channel_recs++;
			compare_field("summary_flag", 32'(want.summary_flag), 32'(got.summary_flag));
			compare_field("chip_sel", 32'(want.chip_sel), 32'(got.chip_sel));
			compare_field("board_channel", 32'(want.board_channel),
				32'(got.board_channel));
			compare_field("absolute_channel", 32'(want.absolute_channel),
				32'(got.absolute_channel));
			compare_field("enabled_index", 32'(want.enabled_index),
				32'(got.enabled_index));
			compare_field("start_byte", 32'(want.start_byte), 32'(got.start_byte));
			compare_field("span_bytes", 32'(want.span_bytes), 32'(got.span_bytes));
			compare_field("right_shift", 32'(want.right_shift), 32'(got.right_shift));
			compare_field("board_bytes", 32'(want.board_bytes), 32'(got.board_bytes));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          cycle_count;
	layout_board layout_sb;

	pclc_in_if  items_if ();
	pclc_out_if results_if ();

	packed_channel_layout_calc dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if.sink),
		.results (results_if.source)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check each accepted descriptor, stall at random
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			layout_sb.check_record('{results_if.summary_flag, results_if.chip_sel,
				results_if.board_channel, results_if.absolute_channel,
				results_if.enabled_index, results_if.start_byte, results_if.span_bytes,
				results_if.right_shift, results_if.board_bytes});
		results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("** packed_channel_layout_calc: FAILED **");
		$finish;
	end

	// offer one board item, holding valid across back-to-back items
	task automatic send_board(input logic [1:0] b, input logic [31:0] m,
		input logic [4:0] s, input logic f);
		board_item_t it;
		int          gap;

		it  = '{b, m, s, f};
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid        <= 1'b1;
		items_if.board_index  <= it.board_index;
		items_if.channel_mask <= it.channel_mask;
		items_if.sample_bits  <= it.sample_bits;
		items_if.first_board  <= it.first_board;
		do
			@(posedge clk);
		while (!items_if.ready);
		layout_sb.note_board(it);
	endtask

	// random board with a mix of mask shapes and mostly legal resolutions
	task automatic send_random_board();
		logic [31:0] m;
		logic [4:0]  s;

		case ($urandom_range(5))
			0: m = $urandom;
			1: m = $urandom & $urandom & $urandom;
			2: m = $urandom | $urandom | $urandom;
			3: m = 32'hFF << (CHIP_CHANNELS_DEF * $urandom_range(CHIP_COUNT_DEF - 1));
			4: m = 32'h1 << $urandom_range(31);
			default: m = $urandom_range(1) ? '1 : '0;
		endcase
		if ($urandom_range(9) == 0)
			s = 5'($urandom_range(31));
		else
			s = 5'($urandom_range(SAMPLE_MAX, 1));
		send_board(2'($urandom_range(3)), m, s, $urandom_range(7) == 0);
	endtask

	initial begin
		layout_sb             = new();
		send_idle_pct         = 0;
		recv_stall_pct        = 0;
		arst_n                <= 1'b0;
		items_if.valid        <= 1'b0;
		items_if.board_index  <= '0;
		items_if.channel_mask <= '0;
		items_if.sample_bits  <= '0;
		items_if.first_board  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty and full boards, resolution extremes and clamping
		send_board(2'd0, 32'h0000_0000, 5'd1, 1'b1);
		send_board(2'd3, 32'hFFFF_FFFF, 5'd16, 1'b1);
		send_board(2'd1, 32'hFFFF_FFFF, 5'd1, 1'b1);
		send_board(2'd2, 32'h0000_0001, 5'd0, 1'b0);
		send_board(2'd0, 32'h8000_0000, 5'd17, 1'b0);
		send_board(2'd1, 32'h8000_0001, 5'd31, 1'b0);
		send_board(2'd2, 32'h5555_5555, 5'd3, 1'b0);
		send_board(2'd3, 32'hAAAA_AAAA, 5'd13, 1'b0);
		send_board(2'd0, 32'h0F0F_0F0F, 5'd7, 1'b1);
		send_board(2'd1, 32'h00FF_FF00, 5'd9, 1'b0);
		send_board(2'd2, 32'hFF00_00FF, 5'd15, 1'b0);
		send_board(2'd3, 32'h8181_8181, 5'd8, 1'b0);
		// directed: running index saturation across four full boards
		send_board(2'd0, 32'hFFFF_FFFF, 5'd12, 1'b1);
		send_board(2'd1, 32'hFFFF_FFFF, 5'd12, 1'b0);
		send_board(2'd2, 32'hFFFF_FFFF, 5'd12, 1'b0);
		send_board(2'd3, 32'hFFFF_FFFF, 5'd12, 1'b0);
		send_board(2'd0, 32'h1234_5678, 5'd5, 1'b0);
		send_board(2'd1, 32'h0000_0003, 5'd4, 1'b1);

		// random phases with different idling patterns
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			repeat (ITEMS_PER_PHASE) send_random_board();
		end
		items_if.valid <= 1'b0;

		// drain, then watch for stray descriptors
		while (layout_sb.pending.size() != 0)
			@(posedge clk);
		repeat (SCAN_CYCLES + 8) @(posedge clk);
		if (layout_sb.pending.size() != 0)
			layout_sb.errors++;

		$display("covered %0d boards: %0d channel descriptors, %0d board summaries",
			layout_sb.boards, layout_sb.channel_recs, layout_sb.summaries);
		$display("%0d descriptors at the saturated index, %0d mismatches",
			layout_sb.saturated_recs, layout_sb.errors);
		if (layout_sb.errors == 0)
			$display("** packed_channel_layout_calc: PASSED **");
		else
			$display("** packed_channel_layout_calc: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/pclc_pkg.sv
rtl/core/pclc_if.sv
rtl/core/pclc_step.sv
rtl/core/pclc_seq.sv
rtl/core/packed_channel_layout_calc.sv
rtl/core/pclc_checker.sv
tb/tb.sv
